FILE: rtl/sounding_frame_builder_crc32_macros.svh
// assertion macros shared by the frame builder modules
`ifndef SOUNDING_FRAME_BUILDER_CRC32_MACROS_SVH
`define SOUNDING_FRAME_BUILDER_CRC32_MACROS_SVH

`ifndef SYNTHESIS
`define SFB_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFB_ASSERT_RST(label, clk, rst_n, prop, msg)
`define SFB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/sfb_pkg.sv
// types, constants and crc function for the sounding frame builder
`timescale 1ns / 1ps

package sfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] PAYLOAD_MAGIC = 32'h3144_4E53;
  localparam logic [15:0] FC_DATA      = 16'h0008;
  localparam logic [15:0] PAYLOAD_VER  = 16'd1;
  localparam logic [15:0] PAYLOAD_LEN  = 16'd48;

  localparam logic [4:0] WORD_CRC_FIRST = 5'd6;
  localparam logic [4:0] WORD_CRC_LAST  = 5'd16;
  localparam logic [4:0] WORD_LAST      = 5'd17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_MAC    = 2'd0,
    CFG_SESSION_TAG   = 2'd1,
    CFG_RADIO_CHANNEL = 2'd2,
    CFG_SOUNDING_RATE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0]        sounding_number;
    logic signed [63:0] time_us;
  } sfb_in_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [4:0]  word_index;
    logic        last_word;
  } sfb_out_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [31:0] session_tag;
    logic [15:0] radio_channel;
    logic [9:0]  sounding_rate;
  } sfb_cfg_t;

  // reflected crc-32 over one little-endian word
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] data);
    logic [31:0] c;
    c = crc ^ data;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/sounding_frame_builder_crc32.sv
// top level of the sounding frame builder with crc-32
`timescale 1ns / 1ps

// Each accepted item yields one 72-byte frame delivered as 18 words, one word per
// cycle from the frame sequencer while the output is not stalled; the crc is folded
// in four bytes a cycle as the payload words go out and the last word carries it.
// The next frame starts in the cycle after the final word of the previous one is
// registered, so frames follow with no gap when an item is waiting. Up to QueueDepth
// items wait in the queue between intake and sequencer. Configuration writes are taken
// every cycle and must only happen while no frame is pending.
module sounding_frame_builder_crc32 #(
  parameter int unsigned QueueDepth = sfb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sfb_pkg::sfb_in_t                in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sfb_pkg::sfb_out_t               out_item_o
);
  import sfb_pkg::*;

  logic     q_full, q_push, q_valid, q_pop;
  sfb_in_t  q_wdata, q_rdata;
  sfb_cfg_t cfg;

  sfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .cfg_o       (cfg)
  );

  sfb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  sfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/sfb_front.sv
// front end: configuration registers and input item intake
`timescale 1ns / 1ps

module sfb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sfb_pkg::sfb_in_t                in_item_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output sfb_pkg::sfb_in_t                q_data_o,
  output sfb_pkg::sfb_cfg_t               cfg_o
);
  import sfb_pkg::*;

  sfb_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;
  assign q_data_o    = in_item_i;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SOURCE_MAC:    cfg_d.source_mac    = cfg_data_i[47:0];
        CFG_SESSION_TAG:   cfg_d.session_tag   = cfg_data_i[31:0];
        CFG_RADIO_CHANNEL: cfg_d.radio_channel = cfg_data_i[15:0];
        CFG_SOUNDING_RATE: cfg_d.sounding_rate = cfg_data_i[9:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_mac    <= '0;
      cfg_q.session_tag   <= '0;
      cfg_q.radio_channel <= 16'd1;
      cfg_q.sounding_rate <= 10'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/sfb_fifo.sv
// short item queue between front end and frame sequencer
`timescale 1ns / 1ps
`include "sounding_frame_builder_crc32_macros.svh"

module sfb_fifo #(
  parameter int unsigned Depth = sfb_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfb_pkg::sfb_in_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sfb_pkg::sfb_in_t data_o
);
  import sfb_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfb_in_t mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SFB_ASSERT_RST(a_fifo_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "queue overfilled")
  `SFB_ASSERT_RST(a_fifo_ptrs_empty, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

FILE: rtl/sfb_back.sv
// frame sequencer: word generation, crc and output register
`timescale 1ns / 1ps
`include "sounding_frame_builder_crc32_macros.svh"

module sfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfb_pkg::sfb_cfg_t cfg_i,
  input  logic              q_valid_i,
  input  sfb_pkg::sfb_in_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfb_pkg::sfb_out_t out_item_o
);
  import sfb_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  sfb_in_t     item_q;
  sfb_out_t    out_q;
  logic        adv, load, at_last;
  logic [31:0] word;

  assign adv     = busy_q && (!out_valid_q || !out_stall_i);
  assign at_last = (cnt_q == WORD_LAST);
  assign load    = q_valid_i && (!busy_q || (adv && at_last));
  assign q_pop_o = load;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    case (cnt_q)
      5'd0:    word = {16'h0000, FC_DATA};
      5'd1:    word = 32'hFFFF_FFFF;
      5'd2:    word = {cfg_i.source_mac[15:0], 16'hFFFF};
      5'd3:    word = cfg_i.source_mac[47:16];
      5'd4:    word = cfg_i.source_mac[31:0];
      5'd5:    word = {item_q.sounding_number[11:0], 4'h0, cfg_i.source_mac[47:32]};
      5'd6:    word = PAYLOAD_MAGIC;
      5'd7:    word = {PAYLOAD_LEN, PAYLOAD_VER};
      5'd8:    word = cfg_i.session_tag;
      5'd9:    word = item_q.sounding_number;
      5'd10:   word = item_q.time_us[31:0];
      5'd11:   word = item_q.time_us[63:32];
      5'd12:   word = {6'h00, cfg_i.sounding_rate, cfg_i.radio_channel};
      5'd17:   word = ~crc_q;
      default: word = '0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q + 1'b1;
      if (cnt_q >= WORD_CRC_FIRST && cnt_q <= WORD_CRC_LAST) begin
        crc_d = crc32_word(crc_q, word);
      end
      if (at_last) begin
        busy_d = 1'b0;
        cnt_d  = '0;
        crc_d  = CRC_INIT;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      crc_d  = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= q_data_i;
    end
    if (adv) begin
      out_q.frame_word <= word;
      out_q.word_index <= cnt_q;
      out_q.last_word  <= at_last;
    end
  end

  `SFB_ASSERT_RST(a_back_cnt_bound, clk_i, rst_ni, cnt_q <= WORD_LAST, "word counter past frame end")
  `SFB_ASSERT_RST(a_back_last_flag, clk_i, rst_ni, out_valid_q |-> (out_q.last_word == (out_q.word_index == WORD_LAST)), "last flag mismatch")
  `SFB_ASSERT_RST(a_back_load_clean, clk_i, rst_ni, (load && busy_q) |-> (adv && at_last), "new item loaded mid frame")
  `SFB_ASSERT_RST(a_back_crc_restart, clk_i, rst_ni, load |=> (busy_q && cnt_q == '0 && crc_q == CRC_INIT), "frame start not set up")

endmodule

FILE: sim/sounding_frame_builder_crc32_tb.sv
// self-checking testbench for the sounding frame builder with crc-32
`timescale 1ns / 1ps

module sounding_frame_builder_crc32_tb;
  import sfb_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  sfb_in_t                in_item_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  sfb_out_t               out_item_o;

  sounding_frame_builder_crc32 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the configuration registers
  logic [47:0] mac_q   = 48'd0;
  logic [31:0] tag_q   = 32'd0;
  logic [15:0] chan_q  = 16'd1;
  logic [9:0]  rate_q  = 10'd1;

  sfb_in_t  pending_items[$];
  sfb_out_t expected_words[$];
  int       items_queued = 0;
  int       items_taken = 0;
  int       frames_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       failed = 1'b0;

  function automatic logic [31:0] fold_crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

  // builds the 18 frame words for one item and queues them
  function automatic void predict_frame(sfb_in_t item);
    logic [31:0] words[18];
    logic [31:0] crc;
    sfb_out_t    res;
    words[0]  = {16'h0000, FC_DATA};
    words[1]  = 32'hFFFF_FFFF;
    words[2]  = {mac_q[15:0], 16'hFFFF};
    words[3]  = mac_q[47:16];
    words[4]  = mac_q[31:0];
    words[5]  = {item.sounding_number[11:0], 4'h0, mac_q[47:32]};
    words[6]  = PAYLOAD_MAGIC;
    words[7]  = {16'd48, 16'd1};
    words[8]  = tag_q;
    words[9]  = item.sounding_number;
    words[10] = item.time_us[31:0];
    words[11] = item.time_us[63:32];
    words[12] = {6'd0, rate_q, chan_q};
    for (int w = 13; w < 17; w++) begin
      words[w] = 32'd0;
    end
    crc = 32'hFFFF_FFFF;
    for (int w = 6; w < 17; w++) begin
      for (int b = 0; b < 4; b++) begin
        crc = fold_crc_byte(crc, words[w][8*b +: 8]);
      end
    end
    words[17] = ~crc;
    for (int w = 0; w < 18; w++) begin
      res.frame_word = words[w];
      res.word_index = 5'(w);
      res.last_word  = (w == 17);
      expected_words.push_back(res);
    end
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_frame(in_item_i);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 &&
            !((items_taken < 150 || items_taken >= 260) && $urandom_range(99) < 20)) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    sfb_out_t exp_word;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h index %0d last %0b", $time,
                   out_item_o.frame_word, out_item_o.word_index, out_item_o.last_word);
          failed = 1'b1;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_item_o.frame_word !== exp_word.frame_word) begin
            $display("%0t: frame_word expected %h actual %h (index %0d)", $time,
                     exp_word.frame_word, out_item_o.frame_word, exp_word.word_index);
            failed = 1'b1;
          end
          if (out_item_o.word_index !== exp_word.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_word.word_index, out_item_o.word_index);
            failed = 1'b1;
          end
          if (out_item_o.last_word !== exp_word.last_word) begin
            $display("%0t: last_word expected %0b actual %0b (index %0d)", $time,
                     exp_word.last_word, out_item_o.last_word, exp_word.word_index);
            failed = 1'b1;
          end
          if (exp_word.last_word) begin
            frames_seen++;
          end
        end
      end
      // one long hold-off to back the block up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && frames_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (frames_seen < 200 || frames_seen >= 300) && ($urandom_range(99) < 20);
      end
    end
  end

  task automatic cfg_write(cfg_reg_e sel, logic [47:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      CFG_SOURCE_MAC:    mac_q   = value;
      CFG_SESSION_TAG:   tag_q   = value[31:0];
      CFG_RADIO_CHANNEL: chan_q  = value[15:0];
      CFG_SOUNDING_RATE: rate_q  = value[9:0];
      default: ;
    endcase
  endtask

  task automatic add_item(logic [31:0] num, logic [63:0] stamp);
    sfb_in_t item;
    item.sounding_number = num;
    item.time_us         = stamp;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (items_taken != items_queued || expected_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    logic [31:0] run_num;
    logic [47:0] rate_val;
    logic [31:0] num;
    logic [63:0] stamp;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset configuration, field extremes
    add_item(32'h0000_0000, 64'h0000_0000_0000_0000);
    add_item(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(32'h0000_0FFF, 64'h8000_0000_0000_0000);
    add_item(32'h0000_1000, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(32'h8000_0000, 64'h0000_0000_0000_0001);
    add_item(32'h7FFF_F001, 64'hFFFF_FFFF_FFF0_BDC0);
    wait_idle();

    // all ones, upper bits dropped, rate above range
    cfg_write(CFG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_SESSION_TAG, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_RADIO_CHANNEL, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_SOUNDING_RATE, 48'hFFFF_FFFF_FFFF);
    add_item(32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
    add_item(32'h0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    wait_idle();

    // zeros, rate below range
    cfg_write(CFG_SOURCE_MAC, 48'h0000_0000_0000);
    cfg_write(CFG_SESSION_TAG, 48'hABCD_0000_0000);
    cfg_write(CFG_RADIO_CHANNEL, 48'h0000_0000_0000);
    cfg_write(CFG_SOUNDING_RATE, 48'h0000_0000_0000);
    add_item(32'h0000_0000, 64'h0000_0000_0000_0000);
    add_item(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_idle();

    // typical values, rate at its limits
    cfg_write(CFG_SOURCE_MAC, 48'h0605_0403_0201);
    cfg_write(CFG_SESSION_TAG, 48'h0000_DEAD_BEEF);
    cfg_write(CFG_RADIO_CHANNEL, 48'd11);
    cfg_write(CFG_SOUNDING_RATE, 48'd1000);
    add_item(32'd1, 64'd1_700_000_000_000_000);
    add_item(32'd2, 64'd1_700_000_000_001_000);
    wait_idle();
    cfg_write(CFG_SOUNDING_RATE, 48'd1001);
    add_item(32'd3, 64'd1_700_000_000_002_000);
    add_item(32'd4095, 64'hFFFF_FFFF_FFFF_FC18);
    wait_idle();

    // random phases
    for (int p = 0; p < 5; p++) begin
      cfg_write(CFG_SOURCE_MAC, rand48());
      cfg_write(CFG_SESSION_TAG, rand48());
      cfg_write(CFG_RADIO_CHANNEL, rand48());
      rate_val = rand48();
      if ($urandom_range(99) < 60) begin
        rate_val[9:0] = 10'($urandom_range(1000, 1));
      end
      cfg_write(CFG_SOUNDING_RATE, rate_val);
      run_num = $urandom;
      for (int k = 0; k < 88; k++) begin
        case ($urandom_range(3))
          0: num = $urandom;
          1: num = run_num + k;
          2: num = {20'($urandom), ($urandom_range(1) != 0) ? 12'hFFF : 12'h000};
          default: num = $urandom_range(4095);
        endcase
        case ($urandom_range(2))
          0: stamp = {32'($urandom), 32'($urandom)};
          1: stamp = 64'($urandom_range(2000000));
          default: stamp = -64'($urandom_range(2000000));
        endcase
        add_item(num, stamp);
      end
      wait_idle();
    end

    repeat (30) @(posedge clk_i);
    if (!failed) begin
      $display("[sounding_frame_builder_crc32] OK");
    end else begin
      $display("[sounding_frame_builder_crc32] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[sounding_frame_builder_crc32] ERROR");
    $finish;
  end

endmodule
